// File: rtl/core/calrec_pkg.sv
package calrec_pkg;

    localparam int unsigned POS_W = 5;

    localparam logic [POS_W-1:0] POS_MAGIC_END   = POS_W'(3);
    localparam logic [POS_W-1:0] POS_HEADER_END  = POS_W'(7);
    localparam logic [POS_W-1:0] POS_POLES_END   = POS_W'(11);
    localparam logic [POS_W-1:0] POS_ANGLE_END   = POS_W'(15);
    localparam logic [POS_W-1:0] POS_DIR_END     = POS_W'(19);
    localparam logic [POS_W-1:0] POS_CRC_START   = POS_W'(20);
    localparam logic [POS_W-1:0] POS_LAST        = POS_W'(23);

    localparam logic [31:0] REC_MAGIC          = 32'h5848_4341;
    localparam logic [31:0] REC_HEADER2        = 32'h0018_0001;
    localparam logic [31:0] CRC_POLY           = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT           = 32'hFFFF_FFFF;
    localparam logic [31:0] ANGLE_MAX_BITS     = 32'h40C9_0FDB;
    localparam logic [31:0] NEG_ZERO_BITS      = 32'h8000_0000;
    localparam logic [31:0] DIR_POS            = 32'h0000_0001;
    localparam logic [31:0] DIR_NEG            = 32'hFFFF_FFFF;
    localparam logic [7:0]  ERASED_BYTE        = 8'hFF;

    typedef enum logic [1:0] {
        STATUS_VALID   = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    // Reflected CRC-32, one byte, LSB first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            crc = (crc >> 1) ^ (CRC_POLY & {32{crc[0]}});
        end
        return crc;
    endfunction

endpackage

// File: rtl/core/calib_record_checker.sv
// The status is registered: it appears in the output register in the cycle after byte 23 is accepted.
// Throughput: one record byte per cycle while in_stall is low; one status per 24 bytes. The byte-wide CRC
// update and field capture are done together for each accepted byte.
// Input stalls only when byte 23 is offered while the previous status is held and stalled.
// Reset (rst_n low, asynchronous): expected pole pairs 0, record state cleared, CRC all ones,
// output register empty.
module calib_record_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [31:0]        cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               read_ok,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [31:0]        angle_offset_bits,
    output logic signed [1:0]  sensor_direction
);
    import calrec_pkg::*;

    logic [31:0]      expected_reg;
    logic [POS_W-1:0] byte_position_reg, byte_position_next;
    logic [31:0]      running_crc_reg, running_crc_next;
    logic             all_erased_reg, all_erased_next;
    logic             read_failed_reg, read_failed_next;
    logic             header_mismatch_reg, header_mismatch_next;
    logic [31:0]      field_shift_reg, field_shift_next;
    logic [31:0]      pole_count_reg, pole_count_next;
    logic [31:0]      angle_reg, angle_next;
    logic [31:0]      direction_reg, direction_next;

    logic             out_valid_reg, out_valid_next;
    status_t          status_reg, status_next;
    logic [31:0]      angle_out_reg, angle_out_next;
    logic [1:0]       dir_out_reg, dir_out_next;

    logic             in_accept;
    logic             last_byte;
    logic             record_good;

    assign last_byte = (byte_position_reg == POS_LAST);
    // Hold the last byte back only when the finished status cannot move.
    assign in_stall  = last_byte && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign angle_offset_bits = angle_out_reg;
    assign sensor_direction  = dir_out_reg;

    always_comb
    begin
        field_shift_next     = {data_byte, field_shift_reg[31:8]};
        read_failed_next     = read_failed_reg || !read_ok;
        all_erased_next      = all_erased_reg && (data_byte == ERASED_BYTE);
        running_crc_next     = running_crc_reg;
        if (byte_position_reg < POS_CRC_START)
        begin
            running_crc_next = crc_byte(running_crc_reg, data_byte);
        end
        header_mismatch_next = header_mismatch_reg;
        if ((byte_position_reg == POS_MAGIC_END) && (field_shift_next != REC_MAGIC))
        begin
            header_mismatch_next = 1'b1;
        end
        if ((byte_position_reg == POS_HEADER_END) && (field_shift_next != REC_HEADER2))
        begin
            header_mismatch_next = 1'b1;
        end
        pole_count_next = (byte_position_reg == POS_POLES_END) ? field_shift_next
                                                                : pole_count_reg;
        angle_next      = (byte_position_reg == POS_ANGLE_END) ? field_shift_next
                                                                : angle_reg;
        direction_next  = (byte_position_reg == POS_DIR_END)   ? field_shift_next
                                                                : direction_reg;
        byte_position_next = byte_position_reg + POS_W'(1);

        record_good = !header_mismatch_reg
                   && (pole_count_reg == expected_reg)
                   && (field_shift_next == ~running_crc_reg)
                   && (pole_count_reg != 32'd0)
                   && ((angle_reg <= ANGLE_MAX_BITS) || (angle_reg == NEG_ZERO_BITS))
                   && ((direction_reg == DIR_POS) || (direction_reg == DIR_NEG));

        if (read_failed_next)
        begin
            status_next = STATUS_INVALID;
        end
        else if (all_erased_next)
        begin
            status_next = STATUS_EMPTY;
        end
        else if (record_good)
        begin
            status_next = STATUS_VALID;
        end
        else
        begin
            status_next = STATUS_INVALID;
        end
        angle_out_next = (status_next == STATUS_VALID) ? angle_reg : 32'd0;
        dir_out_next   = (status_next == STATUS_VALID) ? direction_reg[1:0] : 2'd0;

        out_valid_next = out_valid_reg && out_stall;
        if (in_accept && last_byte)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= 32'd0;
        end
        else if (cfg_write_en)
        begin
            expected_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg   <= '0;
            running_crc_reg     <= CRC_INIT;
            all_erased_reg      <= 1'b1;
            read_failed_reg     <= 1'b0;
            header_mismatch_reg <= 1'b0;
            field_shift_reg     <= 32'd0;
            pole_count_reg      <= 32'd0;
            angle_reg           <= 32'd0;
            direction_reg       <= 32'd0;
        end
        else if (in_accept)
        begin
            if (last_byte)
            begin
                // Drop all record state for the next record.
                byte_position_reg   <= '0;
                running_crc_reg     <= CRC_INIT;
                all_erased_reg      <= 1'b1;
                read_failed_reg     <= 1'b0;
                header_mismatch_reg <= 1'b0;
                field_shift_reg     <= 32'd0;
                pole_count_reg      <= 32'd0;
                angle_reg           <= 32'd0;
                direction_reg       <= 32'd0;
            end
            else
            begin
                byte_position_reg   <= byte_position_next;
                running_crc_reg     <= running_crc_next;
                all_erased_reg      <= all_erased_next;
                read_failed_reg     <= read_failed_next;
                header_mismatch_reg <= header_mismatch_next;
                field_shift_reg     <= field_shift_next;
                pole_count_reg      <= pole_count_next;
                angle_reg           <= angle_next;
                direction_reg       <= direction_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && last_byte)
        begin
            status_reg    <= status_next;
            angle_out_reg <= angle_out_next;
            dir_out_reg   <= dir_out_next;
        end
    end

`ifndef SYNTH
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_position_reg <= POS_LAST)
        else $error("byte position beyond last record byte");

    a_last_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last_byte) |=> (out_valid_reg && (byte_position_reg == '0)
                                      && all_erased_reg && !read_failed_reg))
        else $error("record end did not load status or clear record state");

    a_no_result_midrecord: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !(in_accept && last_byte)) |=> !out_valid_reg)
        else $error("status appeared without a completed record");

    a_zero_unless_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != STATUS_VALID))
            |-> ((angle_out_reg == 32'd0) && (dir_out_reg == 2'd0)))
        else $error("payload not zero on non-valid status");

    a_valid_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == STATUS_VALID))
            |-> ((dir_out_reg == 2'b01) || (dir_out_reg == 2'b11)))
        else $error("valid status with bad direction");
`endif

endmodule

// File: verif/tb_calib_record_checker.sv
`timescale 1ns / 1ps

import calrec_pkg::*;

// Record image, byte i at rec[i]; a 4-byte slice reads back as a little-endian word.
typedef logic [23:0][7:0] record_t;

typedef struct {
    status_t            st;
    logic [31:0]        angle;
    logic signed [1:0]  dir;
} verdict_t;

// Reflected CRC-32, one byte, bit 0 first.
function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic [7:0]  d;
    c = crc;
    d = b;
    for (int k = 0; k < 8; k++)
    begin
        if ((c[0] ^ d[0]) == 1'b1)
            c = (c >> 1) ^ CRC_POLY;
        else
            c = c >> 1;
        d = d >> 1;
    end
    return c;
endfunction

class record_verdict_board;
    logic [31:0] pole_pairs;
    logic [4:0]  pos;
    logic [31:0] crc;
    logic        erased;
    logic        failed;
    logic        hdr_bad;
    logic [31:0] shift;
    logic [31:0] poles;
    logic [31:0] angle;
    logic [31:0] dir;
    verdict_t    pending_verdicts[$];
    int          mismatch_count;
    int          checked_count;
    int          valid_count;
    int          empty_count;
    int          invalid_count;

    function new();
        pole_pairs     = '0;
        mismatch_count = 0;
        checked_count  = 0;
        valid_count    = 0;
        empty_count    = 0;
        invalid_count  = 0;
        clear_record();
    endfunction

    function void clear_record();
        pos     = '0;
        crc     = CRC_INIT;
        erased  = 1'b1;
        failed  = 1'b0;
        hdr_bad = 1'b0;
        shift   = '0;
        poles   = '0;
        angle   = '0;
        dir     = '0;
    endfunction

    function void set_pole_pairs(logic [31:0] v);
        pole_pairs = v;
    endfunction

    function int pending();
        return pending_verdicts.size();
    endfunction

    function void note_byte(logic [7:0] b, logic ok);
        verdict_t v;
        logic     angle_in_range;
        if (!ok)
            failed = 1'b1;
        if (b != ERASED_BYTE)
            erased = 1'b0;
        if (pos < POS_CRC_START)
            crc = crc32_step(crc, b);
        shift = {b, shift[31:8]};
        case (pos)
            POS_MAGIC_END:  if (shift != REC_MAGIC) hdr_bad = 1'b1;
            POS_HEADER_END: if (shift != REC_HEADER2) hdr_bad = 1'b1;
            POS_POLES_END:  poles = shift;
            POS_ANGLE_END:  angle = shift;
            POS_DIR_END:    dir = shift;
            default: ;
        endcase
        if (pos != POS_LAST)
        begin
            pos = pos + 1'b1;
            return;
        end
        v.st    = STATUS_INVALID;
        v.angle = '0;
        v.dir   = '0;
        angle_in_range = (angle <= ANGLE_MAX_BITS) || (angle == NEG_ZERO_BITS);
        if (failed)
            v.st = STATUS_INVALID;
        else if (erased)
            v.st = STATUS_EMPTY;
        else if (!hdr_bad && poles == pole_pairs && shift == ~crc && poles != 0 &&
                 angle_in_range && (dir == DIR_POS || dir == DIR_NEG))
        begin
            v.st    = STATUS_VALID;
            v.angle = angle;
            v.dir   = dir[1:0];
        end
        pending_verdicts.push_back(v);
        clear_record();
    endfunction

    function void check_status(logic [1:0] st, logic [31:0] ang, logic signed [1:0] d);
        verdict_t v;
        checked_count++;
        if (pending_verdicts.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: status %0d angle %h dir %0d with no record pending",
                         $realtime, st, ang, d);
            return;
        end
        v = pending_verdicts.pop_front();
        case (v.st)
            STATUS_VALID: valid_count++;
            STATUS_EMPTY: empty_count++;
            default:      invalid_count++;
        endcase
        if (st !== v.st || ang !== v.angle || d !== v.dir)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: expected status %0d angle %h dir %0d, got %0d %h %0d",
                         $realtime, v.st, v.angle, v.dir, st, ang, d);
        end
    endfunction
endclass

module tb_calib_record_checker;

    localparam int CLK_PERIOD = 12;
    localparam int MAX_CYCLES = 400_000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write_en = 1'b0;
    logic [31:0]       cfg_write_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        data_byte = '0;
    logic              read_ok = 1'b1;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        status;
    logic [31:0]       angle_offset_bits;
    logic signed [1:0] sensor_direction;

    record_verdict_board sb;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          bytes_sent = 0;
    int          settings_used = 1;
    logic [31:0] cur_pole_pairs = '0;

    calib_record_checker i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_write_data    (cfg_write_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .data_byte         (data_byte),
        .read_ok           (read_ok),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .angle_offset_bits (angle_offset_bits),
        .sensor_direction  (sensor_direction)
    );

    always #(CLK_PERIOD / 2.0) clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_status(status, angle_offset_bits, sensor_direction);
    end

    function automatic record_t build_record(logic [31:0] magic, logic [15:0] version,
                                             logic [15:0] size, logic [31:0] poles,
                                             logic [31:0] angle, logic [31:0] dir);
        record_t     r;
        logic [31:0] c;
        r          = '0;
        r[3:0]     = magic;
        r[5:4]     = version;
        r[7:6]     = size;
        r[11:8]    = poles;
        r[15:12]   = angle;
        r[19:16]   = dir;
        c = CRC_INIT;
        for (int i = 0; i < 20; i++)
            c = crc32_step(c, r[i]);
        r[23:20] = ~c;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the byte is taken.
    task automatic send_byte(input logic [7:0] b, input logic ok);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        read_ok   <= ok;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(b, ok);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_record(input record_t r, input logic [23:0] ok_mask);
        for (int i = 0; i < 24; i++)
            send_byte(r[i], ok_mask[i]);
    endtask

    // Drop valid, let every pending status come out, then give the output stage time.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_pole_pairs(input logic [31:0] v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        sb.set_pole_pairs(v);
        cur_pole_pairs = v;
        settings_used++;
    endtask

    function automatic record_t good_record(logic [31:0] angle, logic [31:0] dir);
        return build_record(REC_MAGIC, 16'd1, 16'd24, cur_pole_pairs, angle, dir);
    endfunction

    task automatic send_random_record();
        record_t     r;
        logic [23:0] ok_mask;
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] size;
        logic [31:0] poles;
        logic [31:0] angle;
        logic [31:0] dir;
        int          kind;
        int          flaw;
        magic   = REC_MAGIC;
        version = 16'd1;
        size    = 16'd24;
        poles   = cur_pole_pairs;
        dir     = $urandom_range(1) ? DIR_POS : DIR_NEG;
        case ($urandom_range(3))
            0:       angle = ANGLE_MAX_BITS;
            1:       angle = NEG_ZERO_BITS;
            default: angle = $urandom_range(ANGLE_MAX_BITS, 0);
        endcase
        ok_mask = '1;
        flaw    = -1;
        kind    = $urandom_range(99);
        if (kind >= 50 && kind < 60)
        begin
            r = '1;
            if ($urandom_range(3) == 0)
                ok_mask[$urandom_range(23)] = 1'b0;
            else if ($urandom_range(2) == 0)
                r[$urandom_range(23)][$urandom_range(7)] = 1'b0;
        end
        else if (kind >= 95)
        begin
            for (int i = 0; i < 24; i++)
            begin
                r[i] = $urandom_range(255);
                ok_mask[i] = ($urandom_range(7) != 0);
            end
        end
        else
        begin
            if (kind >= 60 && kind < 85)
                flaw = $urandom_range(7);
            case (flaw)
                0: magic   = magic ^ (32'd1 << $urandom_range(31));
                1: version = version ^ (16'd1 << $urandom_range(15));
                2: size    = size ^ (16'd1 << $urandom_range(15));
                3: poles   = poles ^ (32'd1 << $urandom_range(31));
                4:
                begin
                    angle = $urandom_range(32'hFFFF_FFFF, ANGLE_MAX_BITS + 1);
                    if (angle == NEG_ZERO_BITS)
                        angle = angle + 1;
                end
                5: dir = $urandom();
                default: ;
            endcase
            r = build_record(magic, version, size, poles, angle, dir);
            if (flaw == 6)
                r[20 + $urandom_range(3)][$urandom_range(7)] ^= 1'b1;
            else if (flaw == 7)
                r[$urandom_range(19)][$urandom_range(7)] ^= 1'b1;
            if (kind >= 85)
            begin
                ok_mask[$urandom_range(23)] = 1'b0;
                if ($urandom_range(1))
                    ok_mask[$urandom_range(23)] = 1'b0;
            end
        end
        send_record(r, ok_mask);
    endtask

    initial
    begin
        record_t r;
        logic [31:0] phase_pairs [8];
        sb = new();
        phase_pairs[0] = 32'hFFFF_FFFF;
        phase_pairs[1] = 32'd1;
        phase_pairs[2] = 32'd0;
        phase_pairs[3] = $urandom();
        phase_pairs[4] = 32'h8000_0000;
        phase_pairs[5] = $urandom_range(64, 2);
        phase_pairs[6] = 32'd2;
        phase_pairs[7] = $urandom();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register still at its reset value of zero: no record can pass.
        send_record('1, '1);
        send_record(build_record(REC_MAGIC, 16'd1, 16'd24, 32'd0, 32'd0, DIR_POS), '1);
        send_record('0, '1);
        wait_quiet();

        write_pole_pairs(32'd7);
        send_record(good_record(32'd0, DIR_POS), '1);
        send_record(good_record(ANGLE_MAX_BITS, DIR_NEG), '1);
        send_record(good_record(NEG_ZERO_BITS, DIR_POS), '1);
        send_record(good_record(ANGLE_MAX_BITS + 1, DIR_POS), '1);
        send_record(good_record(NEG_ZERO_BITS + 1, DIR_POS), '1);
        send_record(good_record(32'h7F80_0000, DIR_POS), '1);
        send_record(good_record(32'hFFC0_0000, DIR_NEG), '1);
        send_record(build_record(REC_MAGIC ^ 32'd1, 16'd1, 16'd24, 32'd7, 32'd0, DIR_POS), '1);
        send_record(build_record(REC_MAGIC, 16'd2, 16'd24, 32'd7, 32'd0, DIR_POS), '1);
        send_record(build_record(REC_MAGIC, 16'd1, 16'd23, 32'd7, 32'd0, DIR_POS), '1);
        send_record(build_record(REC_MAGIC, 16'd1, 16'd24, 32'd8, 32'd0, DIR_POS), '1);
        r = good_record(32'h3F80_0000, DIR_POS);
        r[23][7] = ~r[23][7];
        send_record(r, '1);
        send_record(good_record(32'h3F80_0000, 32'd0), '1);
        send_record(good_record(32'h3F80_0000, 32'hFFFF_FFFE), '1);
        send_record(good_record(32'h3F80_0000, DIR_NEG), 24'h7F_FFFF);
        send_record('1, 24'hFF_FFFE);
        r = '1;
        r[23] = 8'hFE;
        send_record(r, '1);
        // A clean record right after failures: nothing may stick across records.
        send_record(good_record(32'h4000_0000, DIR_NEG), '1);
        wait_quiet();

        for (int p = 0; p < 8; p++)
        begin
            write_pole_pairs(phase_pairs[p]);
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 45;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 45;
                end
                default:
                begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            repeat (6) send_random_record();
            wait_quiet();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end

        $display("Sent %0d bytes over %0d pole pair settings; %0d statuses checked",
                 bytes_sent, settings_used, sb.checked_count);
        $display("Expected outcomes: %0d valid, %0d empty, %0d invalid; %0d mismatches",
                 sb.valid_count, sb.empty_count, sb.invalid_count, sb.mismatch_count);
        if (sb.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(MAX_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d statuses outstanding", sb.pending());
        $display("Mismatches found");
        $finish;
    end

endmodule
